// ===== rtl/core/twrs_pkg.sv =====
// shared types and constants for the time window running sum unit
`default_nettype none

package twrs_pkg;

  // fixed field widths
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned AMT_W     = 32;
  localparam int unsigned TOTAL_W   = 38;
  localparam int unsigned CNT_OUT_W = 7;

  // defaults
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam logic [TIME_W-1:0]  WINDOW_RESET = 32'd5000;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};

  // item kind codes
  localparam logic KIND_RECORD = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_CHECK
  } twrs_state_e;

  // one stored sample
  typedef struct packed {
    logic [TIME_W-1:0] stamp;
    logic [AMT_W-1:0]  amount;
  } twrs_entry_t;

  // one result transaction
  typedef struct packed {
    logic [TOTAL_W-1:0]   window_total;
    logic [CNT_OUT_W-1:0] entries_held;
    logic                 refused;
  } twrs_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/time_window_running_sum_unit.sv =====
// A result passes the IDLE and CHECK states, then is registered in the output register;
//   each expired head removed adds a CHECK pass; a stalled output register holds it.
// A new transaction is taken only in IDLE, once the last is reported; removal runs one entry
//   per cycle through the single read port of the sample memory.
// Reset: pointers, count, total and control clear at once, window_q loads 5000;
//   the sample memory is not cleared and needs no clearing pass.
`default_nettype none

module time_window_running_sum_unit
  import twrs_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [TIME_W-1:0]    cfg_wdata_i,
  // input channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 kind_i,
  input  wire logic [TIME_W-1:0]    now_ms_i,
  input  wire logic [AMT_W-1:0]     amount_i,
  // output channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [TOTAL_W-1:0]        window_total_o,
  output logic [CNT_OUT_W-1:0]      entries_held_o,
  output logic                      refused_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);

  logic [TIME_W-1:0] window_q;
  logic              out_valid_q, out_valid_d;
  twrs_result_t      res_q;
  logic              out_free;
  logic              done;
  twrs_result_t      result;

  logic              mem_we, mem_re;
  logic [PTR_W-1:0]  mem_waddr, mem_raddr;
  twrs_entry_t       mem_wdata, mem_rdata;

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WINDOW_RESET;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  twrs_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .now_ms_i    (now_ms_i),
    .amount_i    (amount_i),
    .window_i    (window_q),
    .out_free_i  (out_free),
    .done_o      (done),
    .result_o    (result),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  twrs_mem #(
    .DEPTH (DEPTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = done || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q <= result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign window_total_o = res_q.window_total;
  assign entries_held_o = res_q.entries_held;
  assign refused_o      = res_q.refused;

endmodule

`default_nettype wire

// ===== rtl/core/twrs_mem.sv =====
// sample memory: one write port, one read port with registered read data
`default_nettype none

module twrs_mem
  import twrs_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire twrs_entry_t              wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output twrs_entry_t                   rdata_o
);

  twrs_entry_t mem_q [DEPTH];
  twrs_entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/twrs_ctrl.sv =====
// controller: head pruning, append, pointers, count and running total
`default_nettype none

module twrs_ctrl
  import twrs_pkg::*;
#(
  parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // input transaction
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic                     kind_i,
  input  wire logic [TIME_W-1:0]        now_ms_i,
  input  wire logic [AMT_W-1:0]         amount_i,
  // configuration
  input  wire logic [TIME_W-1:0]        window_i,
  // result toward the output register
  input  wire logic                     out_free_i,
  output logic                          done_o,
  output twrs_result_t                  result_o,
  // memory
  output logic                          mem_we_o,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr_o,
  output twrs_entry_t                   mem_wdata_o,
  output logic                          mem_re_o,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr_o,
  input  wire twrs_entry_t              mem_rdata_i
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  twrs_state_e state_q, state_d;
  logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic               kind_q;
  logic               prune_q;
  logic [TIME_W-1:0]  now_q;
  logic [AMT_W-1:0]   amt_q;

  logic               accept;
  logic [PTR_W-1:0]   head_next, tail_next;
  logic [TIME_W-1:0]  age;
  logic               expired;
  logic               pop;
  logic [TOTAL_W:0]   sum_ext;
  logic [EXT_W-1:0]   cnt_ext;
  logic               refused;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign head_next = (head_q == PTR_LAST) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == PTR_LAST) ? '0 : tail_q + 1'b1;

  // age test on the head entry read last cycle
  assign age     = now_q - mem_rdata_i.stamp;
  assign expired = age > window_i;
  assign pop     = (state_q == ST_CHECK) && prune_q && (cnt_q != '0) && expired;
  assign sum_ext = {1'b0, total_q} + (TOTAL_W + 1)'(amt_q);

  // next state, memory accesses and result
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    total_d     = total_q;
    in_stall_o  = (state_q != ST_IDLE);
    done_o      = 1'b0;
    refused     = 1'b0;
    mem_we_o    = 1'b0;
    mem_waddr_o = tail_q;
    mem_wdata_o = '{stamp: now_q, amount: amt_q};
    mem_re_o    = 1'b0;
    mem_raddr_o = head_q;
    case (state_q)
      ST_IDLE: begin
        // fetch the head entry together with the transaction
        if (accept) begin
          mem_re_o = 1'b1;
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (pop) begin
          // drop the expired head, fetch the next one
          total_d     = (total_q >= TOTAL_W'(mem_rdata_i.amount)) ?
                        total_q - TOTAL_W'(mem_rdata_i.amount) : '0;
          head_d      = head_next;
          cnt_d       = cnt_q - 1'b1;
          mem_re_o    = 1'b1;
          mem_raddr_o = head_next;
        end else if (out_free_i) begin
          // pruning done: append a nonzero record, or refuse it on a full store, and report
          if ((kind_q == KIND_RECORD) && prune_q) begin
            if (cnt_q == CNT_FULL) begin
              refused = 1'b1;
            end else begin
              mem_we_o = 1'b1;
              tail_d   = tail_next;
              cnt_d    = cnt_q + 1'b1;
              total_d  = sum_ext[TOTAL_W] ? TOTAL_MAX : sum_ext[TOTAL_W-1:0];
            end
          end
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign cnt_ext  = EXT_W'(cnt_d);
  assign result_o = '{window_total: total_d,
                      entries_held: cnt_ext[CNT_OUT_W-1:0],
                      refused:      refused};

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // pointers, count and total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      cnt_q   <= '0;
      total_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
    end
  end

  // transaction fields held while it is worked on
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_i;
      now_q   <= now_ms_i;
      amt_q   <= amount_i;
      prune_q <= (kind_i == KIND_QUERY) || (amount_i != '0);
    end
  end

`ifndef ASSERT_OFF
  // count never passes the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_FULL)
    else $error("twrs_ctrl: count above depth");

  // empty or full means the pointers meet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) || (cnt_q == CNT_FULL) |-> head_q == tail_q)
    else $error("twrs_ctrl: pointers apart with empty or full store");

  // partly filled means the pointers differ
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) && (cnt_q != CNT_FULL) |-> head_q != tail_q)
    else $error("twrs_ctrl: pointers equal with partly filled store");

  // an empty store carries no total
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> total_q == '0)
    else $error("twrs_ctrl: nonzero total with empty store");

  // every pop takes exactly one entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("twrs_ctrl: pop did not drop one entry");
`endif

endmodule

`default_nettype wire

// ===== sim/time_window_running_sum_unit_tb.sv =====
// self-checking testbench for the time window running sum unit
module time_window_running_sum_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twrs_pkg::*;

  localparam int unsigned N_DIRECTED = 13;
  localparam int unsigned N_PHASES   = 6;
  localparam int unsigned PHASE_LEN  = 70;

  // one row of the directed table
  typedef struct {
    logic                 kind;
    logic [TIME_W-1:0]    now;
    logic [AMT_W-1:0]     amt;
    bit                   typed;
    logic [TOTAL_W-1:0]   total;
    logic [CNT_OUT_W-1:0] held;
    logic                 refused;
  } directed_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [TIME_W-1:0]    cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic                 kind_i = KIND_RECORD;
  logic [TIME_W-1:0]    now_ms_i = '0;
  logic [AMT_W-1:0]     amount_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [TOTAL_W-1:0]   window_total_o;
  logic [CNT_OUT_W-1:0] entries_held_o;
  logic                 refused_o;

  // predictor state: samples still in the window, their sum, the window length
  twrs_entry_t          window_entries[$];
  logic [TOTAL_W-1:0]   sum_held = '0;
  logic [TIME_W-1:0]    window_len = WINDOW_RESET;

  // results owed by the block, oldest first
  twrs_result_t         totals_due[$];

  bit                   calm = 1'b0;
  int unsigned          mismatches = 0;
  int unsigned          txns_sent = 0;
  int unsigned          txns_checked = 0;
  int unsigned          refusals = 0;
  int unsigned          windows_used = 0;
  directed_row_t        directed_rows[N_DIRECTED];

  time_window_running_sum_unit #(
    .DEPTH(DEPTH_DEFAULT)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .now_ms_i       (now_ms_i),
    .amount_i       (amount_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .window_total_o (window_total_o),
    .entries_held_o (entries_held_o),
    .refused_o      (refused_o)
  );

  // clock
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("%0t: timeout, %0d results still owed", $time, totals_due.size());
    $display("Verification failed");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i = !calm && ($urandom_range(0, 99) < 27);
  end

  // for a query or nonzero amount, prune expired head entries, then apply the transaction
  function automatic twrs_result_t advance_window(input logic kind, input logic [TIME_W-1:0] now,
                                                  input logic [AMT_W-1:0] amt);
    twrs_result_t       res;
    twrs_entry_t        entry;
    logic [TIME_W-1:0]  age;
    logic [TOTAL_W-1:0] head_amt;
    logic [TOTAL_W:0]   wide_sum;
    res = '0;
    if (kind == KIND_QUERY || amt != '0) begin
      while (window_entries.size() > 0) begin
        age = now - window_entries[0].stamp;
        if (age <= window_len) break;
        head_amt = TOTAL_W'(window_entries[0].amount);
        sum_held = (sum_held >= head_amt) ? sum_held - head_amt : '0;
        window_entries.delete(0);
      end
      if (kind == KIND_RECORD) begin
        if (window_entries.size() >= DEPTH_DEFAULT) begin
          res.refused = 1'b1;
          refusals++;
        end else begin
          entry.stamp  = now;
          entry.amount = amt;
          window_entries.insert(window_entries.size(), entry);
          wide_sum = {1'b0, sum_held} + (TOTAL_W + 1)'(amt);
          sum_held = wide_sum[TOTAL_W] ? TOTAL_MAX : wide_sum[TOTAL_W-1:0];
        end
      end
    end
    res.window_total = sum_held;
    res.entries_held = CNT_OUT_W'(window_entries.size());
    return res;
  endfunction

  // present one transaction, wait for acceptance, record what it must return
  task automatic send_txn(input logic kind, input logic [TIME_W-1:0] now,
                          input logic [AMT_W-1:0] amt, input bit typed,
                          input twrs_result_t typed_res);
    twrs_result_t res;
    while (!calm && $urandom_range(0, 99) < 27) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    kind_i     = kind;
    now_ms_i   = now;
    amount_i   = amt;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    res = advance_window(kind, now, amt);
    totals_due.insert(totals_due.size(), typed ? typed_res : res);
    txns_sent++;
  endtask

  // stop sending and let every owed result come back
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (totals_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // new window length, written only while the block is idle
  task automatic set_window(input logic [TIME_W-1:0] len);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = len;
    window_len  = len;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    windows_used++;
  endtask

  // result checker
  always @(posedge clk_i) begin : result_check
    twrs_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (totals_due.size() == 0) begin
        $display("%0t: result with nothing expected: total %0h held %0d refused %0b",
                 $time, window_total_o, entries_held_o, refused_o);
        mismatches++;
      end else begin
        want = totals_due[0];
        totals_due.delete(0);
        txns_checked++;
        if (window_total_o !== want.window_total) begin
          $display("%0t: window_total expected %0h actual %0h",
                   $time, want.window_total, window_total_o);
          mismatches++;
        end
        if (entries_held_o !== want.entries_held) begin
          $display("%0t: entries_held expected %0d actual %0d",
                   $time, want.entries_held, entries_held_o);
          mismatches++;
        end
        if (refused_o !== want.refused) begin
          $display("%0t: refused expected %0b actual %0b", $time, want.refused, refused_o);
          mismatches++;
        end
      end
    end
  end

  // stimulus
  initial begin : stimulus
    twrs_result_t      typed_res;
    logic [TIME_W-1:0] t_now;
    logic [TIME_W-1:0] win_list[N_PHASES];
    logic [AMT_W-1:0]  amt;
    logic              kind;
    longint unsigned   step_max;
    int unsigned       pick;

    // directed table: wrap of the time, age equal to the window, zero amounts,
    // queries with ignored amounts, time going backward, largest amounts
    directed_rows = '{
      '{KIND_QUERY,  32'd0,          32'd0,          1'b1, 38'd0,            7'd0, 1'b0},
      '{KIND_RECORD, 32'd100,        32'd0,          1'b1, 38'd0,            7'd0, 1'b0},
      '{KIND_RECORD, 32'd100,        32'hFFFF_FFFF,  1'b1, 38'hFFFF_FFFF,    7'd1, 1'b0},
      '{KIND_RECORD, 32'd5100,       32'd1,          1'b1, 38'h1_0000_0000,  7'd2, 1'b0},
      '{KIND_QUERY,  32'd5101,       32'd0,          1'b1, 38'd1,            7'd1, 1'b0},
      '{KIND_RECORD, 32'hFFFF_FFFF,  32'd5,          1'b1, 38'd5,            7'd1, 1'b0},
      '{KIND_RECORD, 32'd3,          32'd7,          1'b1, 38'd12,           7'd2, 1'b0},
      '{KIND_QUERY,  32'd0,          32'hFFFF_FFFF,  1'b0, 38'd0,            7'd0, 1'b0},
      '{KIND_RECORD, 32'd2,          32'd0,          1'b0, 38'd0,            7'd0, 1'b0},
      '{KIND_RECORD, 32'd5003,       32'd8,          1'b0, 38'd0,            7'd0, 1'b0},
      '{KIND_QUERY,  32'd10004,      32'hAAAA_AAAA,  1'b0, 38'd0,            7'd0, 1'b0},
      '{KIND_RECORD, 32'h8000_0000,  32'h5555_5555,  1'b0, 38'd0,            7'd0, 1'b0},
      '{KIND_QUERY,  32'h8000_0000,  32'd0,          1'b0, 38'd0,            7'd0, 1'b0}
    };
    win_list = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'($urandom_range(1, 65535)),
                 32'($urandom), WINDOW_RESET};

    // reset
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part under the reset window
    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_res.window_total = directed_rows[i].total;
      typed_res.entries_held = directed_rows[i].held;
      typed_res.refused      = directed_rows[i].refused;
      send_txn(directed_rows[i].kind, directed_rows[i].now, directed_rows[i].amt,
               directed_rows[i].typed, typed_res);
    end

    // random phases, one window length each
    t_now = 32'hFFFF_F000;
    for (int p = 0; p < N_PHASES; p++) begin
      set_window(win_list[p]);
      calm = (p == 2);
      // with the widest window nothing expires: fill the store past full
      if (win_list[p] == 32'hFFFF_FFFF) begin
        for (int i = 0; i < DEPTH_DEFAULT + 2; i++) begin
          send_txn(KIND_RECORD, t_now, 32'hFFFF_FFFF, 1'b0, '0);
        end
      end
      step_max = longint'(win_list[p]) / 8 + 3;
      if (step_max > 64'h7FFF_FFFF) step_max = 64'h7FFF_FFFF;
      for (int i = 0; i < PHASE_LEN; i++) begin
        // time mostly moves forward, sometimes jumps or steps back
        pick = $urandom_range(0, 99);
        if (pick < 90) t_now = t_now + TIME_W'($urandom_range(0, int'(step_max)));
        else if (pick < 95) t_now = TIME_W'($urandom);
        else t_now = t_now - TIME_W'($urandom_range(1, 100));
        pick = $urandom_range(0, 9);
        if (pick == 0) amt = '0;
        else if (pick == 1) amt = 32'hFFFF_FFFF;
        else if (pick == 2) amt = AMT_W'($urandom_range(1, 15));
        else amt = AMT_W'($urandom);
        kind = ($urandom_range(0, 99) < 30) ? KIND_QUERY : KIND_RECORD;
        send_txn(kind, t_now, amt, 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain_results();
    repeat (10) @(posedge clk_i);
    $display("sent %0d transactions over %0d window settings, checked %0d results",
             txns_sent, windows_used, txns_checked);
    $display("records refused on a full store: %0d, mismatches: %0d", refusals, mismatches);
    if (mismatches == 0 && totals_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/twrs_pkg.sv
rtl/core/twrs_mem.sv
rtl/core/twrs_ctrl.sv
rtl/core/time_window_running_sum_unit.sv
sim/time_window_running_sum_unit_tb.sv
